/* hdl/assert_macros.svh */
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/tlbpt_pkg.sv */
package tlbpt_pkg;

    localparam int VA_W       = 16;
    localparam int CNT_W      = 32;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 2;

    // bit positions of the flags in the output tuser
    localparam int USER_HIT   = 0;
    localparam int USER_FAULT = 1;

    typedef struct packed {
        logic [CNT_W-1:0] fault_total;
        logic [CNT_W-1:0] hit_total;
        logic [VA_W-1:0]  physical_address;
    } t_result;

    typedef struct packed {
        logic page_fault;
        logic tlb_hit;
    } t_flags;

endpackage

/* hdl/tlb_page_table_translator.sv */
// channel     | dir | tdata (low bit up)                             | tuser
// ------------+-----+------------------------------------------------+----------------------
// s_axis      | in  | virtual_address[15:0]                          | -
// m_axis      | out | physical_address[15:0], hit_total[47:16],      | tlb_hit[0],
//             |     | fault_total[79:48]                             | page_fault[1]
//
// one address at a time: the accept cycle issues the page table read; the look state then
// compares the tlb, writes back on a fault, refills the tlb and loads the result, and no
// new address is taken until it is done. the single-port page table read-then-write sets this order.
// after reset a clearing pass wipes all 2**PAGE_BITS page table entries; no input
// is taken until it ends. a stalled output holds the look state, input waits.
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_BITS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [tlbpt_pkg::VA_W-1:0]          i_s_axis_tdata,  // virtual_address
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [tlbpt_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,  // physical_address,
                                                                 // hit_total, fault_total
    output logic [tlbpt_pkg::OUT_USER_W-1:0]    o_m_axis_tuser   // tlb_hit, page_fault
);

    localparam int VA_W    = tlbpt_pkg::VA_W;
    localparam int CNT_W   = tlbpt_pkg::CNT_W;
    localparam int OFF_W   = VA_W - PAGE_BITS;
    localparam int PT_DEPTH = 1 << PAGE_BITS;
    localparam int PTR_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [PAGE_BITS-1:0]   r_clr_addr;
    logic [VA_W-1:0]        r_va;

    // page table entry: valid bit above the frame
    logic [PAGE_BITS:0]     r_pt_mem [PT_DEPTH];
    logic [PAGE_BITS:0]     r_pt_rd;

    logic [PAGE_BITS-1:0]   r_tlb_tag  [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]   r_tlb_data [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [PTR_W-1:0]       r_fifo_ptr;

    logic [PAGE_BITS:0]     r_next_free;
    logic [CNT_W-1:0]       r_hit_cnt;
    logic [CNT_W-1:0]       r_fault_cnt;

    logic                   r_out_valid;
    tlbpt_pkg::t_result     r_out_data;
    tlbpt_pkg::t_flags      r_out_flags;

    logic                   in_xfer;
    logic                   do_look;
    logic [PAGE_BITS-1:0]   look_page;
    logic                   tlb_hit;
    logic [PAGE_BITS-1:0]   tlb_frame;
    logic                   fault;
    logic [PAGE_BITS-1:0]   frame;
    logic                   pt_we;
    logic [PAGE_BITS-1:0]   pt_waddr;
    logic [PAGE_BITS:0]     pt_wdata;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign do_look         = (r_state == S_LOOK) && (!r_out_valid || i_m_axis_tready);
    assign look_page       = r_va[VA_W-1 -: PAGE_BITS];

    // parallel tag compare, highest index wins
    always_comb begin
        tlb_hit   = 1'b0;
        tlb_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (r_tlb_valid[i] && r_tlb_tag[i] == look_page) begin
                tlb_hit   = 1'b1;
                tlb_frame = r_tlb_data[i];
            end
        end
    end

    always_comb begin
        fault = !tlb_hit && !r_pt_rd[PAGE_BITS];
        priority if (tlb_hit) begin
            frame = tlb_frame;
        end else if (fault) begin
            frame = r_next_free[PAGE_BITS-1:0];
        end else begin
            frame = r_pt_rd[PAGE_BITS-1:0];
        end
    end

    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = look_page;
        pt_wdata = {1'b1, r_next_free[PAGE_BITS-1:0]};
        if (r_state == S_CLEAR) begin
            pt_we    = 1'b1;
            pt_waddr = r_clr_addr;
            pt_wdata = '0;
        end else if (do_look && fault) begin
            pt_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[pt_waddr] <= pt_wdata;
        end
        if (in_xfer) begin
            r_pt_rd <= r_pt_mem[i_s_axis_tdata[VA_W-1 -: PAGE_BITS]];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == {PAGE_BITS{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_xfer) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (do_look) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_tlb_valid <= '0;
            r_fifo_ptr  <= '0;
            r_next_free <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + PAGE_BITS'(1);
            end
            if (do_look) begin
                r_out_valid <= 1'b1;
                if (tlb_hit) begin
                    r_hit_cnt <= r_hit_cnt + CNT_W'(1);
                end else begin
                    r_tlb_valid[r_fifo_ptr] <= 1'b1;
                    if (r_fifo_ptr == PTR_W'(TLB_ENTRIES - 1)) begin
                        r_fifo_ptr <= '0;
                    end else begin
                        r_fifo_ptr <= r_fifo_ptr + PTR_W'(1);
                    end
                end
                if (fault) begin
                    r_next_free <= r_next_free + (PAGE_BITS+1)'(1);
                    r_fault_cnt <= r_fault_cnt + CNT_W'(1);
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: input address capture, tlb refill and result register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_va <= i_s_axis_tdata;
        end
        if (do_look) begin
            if (!tlb_hit) begin
                r_tlb_tag[r_fifo_ptr]  <= look_page;
                r_tlb_data[r_fifo_ptr] <= frame;
            end
            r_out_data.physical_address <= {frame, r_va[OFF_W-1:0]};
            r_out_data.hit_total        <= tlb_hit ? r_hit_cnt + CNT_W'(1) : r_hit_cnt;
            r_out_data.fault_total      <= fault ? r_fault_cnt + CNT_W'(1) : r_fault_cnt;
            r_out_flags.tlb_hit         <= tlb_hit;
            r_out_flags.page_fault      <= fault;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_flags;

endmodule

/* hdl/tlbpt_checker.sv */
`include "assert_macros.svh"

module tlbpt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [tlbpt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [tlbpt_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);

    // a stalled result holds its payload
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)), "stalled result changed")

    // a tlb hit never faults
    `CHK_ASSERT(a_hit_no_fault, i_clk, i_rst_n, o_m_axis_tvalid |-> !(o_m_axis_tuser[tlbpt_pkg::USER_HIT] && o_m_axis_tuser[tlbpt_pkg::USER_FAULT]), "hit and fault together")

    // one address in flight: no transfer on the cycle after an input transfer
    `CHK_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready, "input taken while busy")

    // the clearing pass keeps input closed straight after reset
    `CHK_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !o_s_axis_tready, "input open during clearing pass")

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* sim/tb_tlb_page_table_translator.sv */
`timescale 1ns / 100ps

module tb_tlb_page_table_translator;

    localparam int VA_W       = tlbpt_pkg::VA_W;
    localparam int CNT_W      = tlbpt_pkg::CNT_W;
    localparam int OUT_DATA_W = tlbpt_pkg::OUT_DATA_W;
    localparam int OUT_USER_W = tlbpt_pkg::OUT_USER_W;
    localparam int TLB_DEPTH = 16;
    localparam int PAGE_W    = 8;
    localparam int OFF_W     = VA_W - PAGE_W;
    localparam int PAGES     = 1 << PAGE_W;
    localparam int N_RANDOM  = 500;
    localparam int IDLE_PCT  = 18;
    localparam int CALM_LO   = 200;
    localparam int CALM_HI   = 320;

    typedef struct packed {
        logic [VA_W-1:0] addr;
        logic            drain_first;
    } t_access;

    typedef struct packed {
        logic [VA_W-1:0]  physical_address;
        logic             tlb_hit;
        logic             page_fault;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] fault_total;
    } t_translation;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [VA_W-1:0]       i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;  // physical_address, hit_total, fault_total
    logic [OUT_USER_W-1:0] o_m_axis_tuser;  // tlb_hit, page_fault

    t_access      accesses[$];
    t_translation translations[$];
    int           failures = 0;
    int           sent = 0;
    int           received = 0;

    // shadow of the translator state
    logic [PAGE_W-1:0] tlb_page  [TLB_DEPTH];
    logic [PAGE_W-1:0] tlb_frame [TLB_DEPTH];
    bit                tlb_used  [TLB_DEPTH];
    int unsigned       tlb_fill = 0;
    logic [PAGE_W-1:0] frame_of  [PAGES];
    bit                mapped    [PAGES];
    logic [PAGE_W:0]   free_frame = '0;
    logic [CNT_W-1:0]  hits = '0;
    logic [CNT_W-1:0]  faults = '0;

    tlb_page_table_translator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_translation translate(input logic [VA_W-1:0] va);
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] frame;
        t_translation      r;
        page  = va[VA_W-1 -: PAGE_W];
        frame = '0;
        r     = '0;
        // highest matching entry wins
        for (int i = 0; i < TLB_DEPTH; i++) begin
            if (tlb_used[i] && tlb_page[i] == page) begin
                frame     = tlb_frame[i];
                r.tlb_hit = 1'b1;
            end
        end
        if (r.tlb_hit) begin
            hits = hits + 1'b1;
        end else begin
            if (!mapped[page]) begin
                frame_of[page] = free_frame[PAGE_W-1:0];
                mapped[page]   = 1'b1;
                free_frame     = free_frame + 1'b1;
                faults         = faults + 1'b1;
                r.page_fault   = 1'b1;
            end
            frame               = frame_of[page];
            tlb_page[tlb_fill]  = page;
            tlb_frame[tlb_fill] = frame;
            tlb_used[tlb_fill]  = 1'b1;
            tlb_fill            = (tlb_fill + 1) % TLB_DEPTH;
        end
        r.physical_address = {frame, va[OFF_W-1:0]};
        r.hit_total        = hits;
        r.fault_total      = faults;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    task automatic add_access(input logic [VA_W-1:0] addr, input logic drain_first);
        t_access a;
        a.addr        = addr;
        a.drain_first = drain_first;
        accesses.push_back(a);
    endtask

    // address driver
    always @(posedge i_clk) begin : drive
        bit holding;
        bit present;
        if (i_rst_n) begin
            holding = i_s_axis_tvalid && !o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                translations.push_back(translate(i_s_axis_tdata));
                accesses.delete(0);
                sent++;
            end
            if (holding) begin
                present = 1'b1;
            end else if (accesses.size() == 0) begin
                present = 1'b0;
            end else if (accesses[0].drain_first && translations.size() != 0) begin
                present = 1'b0;
            end else if (sent >= CALM_LO && sent < CALM_HI) begin
                present = 1'b1;
            end else begin
                present = $urandom_range(99) >= IDLE_PCT;
            end
            i_s_axis_tvalid <= present;
            if (present && !holding) begin
                i_s_axis_tdata <= accesses[0].addr;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : monitor
        tlbpt_pkg::t_result data;
        tlbpt_pkg::t_flags  flags;
        t_translation       want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                data  = o_m_axis_tdata;
                flags = o_m_axis_tuser;
                received++;
                if (translations.size() == 0) begin
                    $error("transfer with nothing expected: tdata 0x%0h tuser 0x%0h",
                           o_m_axis_tdata, o_m_axis_tuser);
                    failures++;
                end else begin
                    want = translations.pop_front();
                    check_field("physical_address", want.physical_address,
                                data.physical_address);
                    check_field("tlb_hit", want.tlb_hit, flags.tlb_hit);
                    check_field("page_fault", want.page_fault, flags.page_fault);
                    check_field("hit_total", want.hit_total, data.hit_total);
                    check_field("fault_total", want.fault_total, data.fault_total);
                end
            end
            if (received >= CALM_LO && received < CALM_HI) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    initial begin : stimulus
        logic [PAGE_W-1:0] page;
        int                base;
        // corners of the address space, then hits on both end pages
        add_access(16'h0000, 1'b0);
        add_access(16'hFFFF, 1'b0);
        add_access(16'h00FF, 1'b0);
        add_access(16'hFF00, 1'b0);
        // sixteen fresh pages push pages 0x00 and 0xff out of the tlb
        for (int i = 1; i <= 16; i++) begin
            add_access({i[PAGE_W-1:0], i[7:0] ^ 8'h5A}, 1'b0);
        end
        // tlb misses that find a frame already in the page table, then a tlb hit on page 0x10
        add_access(16'h00AB, 1'b0);
        add_access(16'hFFA5, 1'b0);
        add_access(16'h10C3, 1'b0);

        // a working window drifting across every page, with some noise
        for (int k = 0; k < N_RANDOM; k++) begin
            base = k * PAGES / N_RANDOM;
            page = PAGE_W'(base + int'($urandom_range(19)));
            if ($urandom_range(99) < 15) begin
                add_access(VA_W'($urandom), k == 0 || k == N_RANDOM / 2);
            end else begin
                add_access({page, 8'($urandom)}, k == 0 || k == N_RANDOM / 2);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accesses.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (translations.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("** tlb_page_table_translator: PASSED **");
        end else begin
            $display("** tlb_page_table_translator: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** tlb_page_table_translator: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tlbpt_pkg.sv
hdl/tlb_page_table_translator.sv
hdl/tlbpt_checker.sv
sim/tb_tlb_page_table_translator.sv
